### sv/isc_pkg.sv
// Package for the integer stack calculator: instruction codes, status codes
// and the result record shared by the buffer and the top level.
// No dependencies.
package isc_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned DEPTH_W  = 7;
	localparam int unsigned STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ADD    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SUB    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_MUL    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_FINISH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

	typedef struct packed {
		logic signed [WORD_W-1:0] top_value;
		logic [DEPTH_W-1:0]       stack_depth;
		logic [STATUS_W-1:0]      status;
		logic                     program_done;
	} res_t;

endpackage

### sv/isc_stream_if.sv
// Valid/ready channel interfaces for instructions and results.
// Depends on isc_pkg for field widths.
interface isc_cmd_if;
	import isc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [ACTION_W-1:0]        action;
	logic signed [WORD_W-1:0]   operand_value;

	modport source (output valid, output action, output operand_value, input ready);
	modport sink (input valid, input action, input operand_value, output ready);
endinterface

interface isc_res_if;
	import isc_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [WORD_W-1:0]   top_value;
	logic [DEPTH_W-1:0]         stack_depth;
	logic [STATUS_W-1:0]        status;
	logic                       program_done;

	modport source (output valid, output top_value, output stack_depth, output status,
		output program_done, input ready);
	modport sink (input valid, input top_value, input stack_depth, input status,
		input program_done, output ready);
endinterface

### sv/integer_stack_calculator.sv
// Integer stack calculator: push, add, subtract, multiply and finish.
// Each result is registered in the two-entry result buffer before it is offered.
// Throughput: one instruction per cycle unless the result buffer is full.
// Top two entries sit in registers; the next is prefetched from memory every cycle.
// Reset empties the stack and the result buffer; memory contents are not cleared.
// Depends on isc_pkg, isc_stream_if, isc_stack_mem and isc_out_buf.
module integer_stack_calculator #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input logic       clk,
	input logic       arst_n,
	isc_cmd_if.sink   cmd,
	isc_res_if.source res
);
	import isc_pkg::*;

	localparam int unsigned AW  = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

	logic [WORD_W-1:0] top_q, sec_q, top_d, sec_d;
	logic [SPW-1:0]    sp_q, sp_d;
	logic [WORD_W-1:0] below;
	logic [WORD_W-1:0] alu;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] report;
	logic [STATUS_W-1:0] status;
	logic              done;
	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic              fire;
	logic              buf_ready;
	logic              sp_ge2, sp_full;
	res_t              res_in, res_out;

	assign cmd.ready = buf_ready;
	assign fire      = cmd.valid && buf_ready;
	assign sp_ge2    = (sp_q >= SPW'(2));
	assign sp_full   = (sp_q >= SPW'(STACK_DEPTH));
	assign prod      = sec_q * top_q;

	always_comb begin
		unique case (cmd.action)
			ACT_ADD: alu = sec_q + top_q;
			ACT_SUB: alu = sec_q - top_q;
			default: alu = prod;
		endcase
	end

	// Entries at index sp-2 and up are cached in sec_q and top_q; the memory
	// holds the rest, and the entry at index sp-3 is read ahead every cycle.
	always_comb begin
		top_d  = top_q;
		sec_d  = sec_q;
		sp_d   = sp_q;
		we     = 1'b0;
		status = ST_OK;
		done   = 1'b0;
		if (fire) begin
			unique case (cmd.action)
				ACT_PUSH: begin
					if (sp_full) begin
						status = ST_OVER;
					end else begin
						top_d = cmd.operand_value;
						sec_d = top_q;
						sp_d  = sp_q + SPW'(1);
						we    = sp_ge2;
					end
				end
				ACT_ADD, ACT_SUB, ACT_MUL: begin
					if (!sp_ge2) begin
						status = ST_UNDER;
					end else begin
						top_d = alu;
						sec_d = below;
						sp_d  = sp_q - SPW'(1);
					end
				end
				ACT_FINISH: begin
					done = 1'b1;
					sp_d = '0;
					if (sp_q == '0) begin
						status = ST_UNDER;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (done) begin
			report = (sp_q == '0) ? '0 : top_q;
		end else begin
			report = (sp_d == '0) ? '0 : top_d;
		end
	end

	assign waddr = AW'(sp_q - SPW'(2));
	assign raddr = AW'(sp_d - SPW'(3));

	assign res_in.top_value    = report;
	assign res_in.stack_depth  = DEPTH_W'(sp_d);
	assign res_in.status       = status;
	assign res_in.program_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			sp_q <= sp_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		sec_q <= sec_d;
	end

	isc_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (sec_q),
		.raddr  (raddr),
		.rdata  (below)
	);

	isc_out_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fire),
		.in_ready  (buf_ready),
		.in_data   (res_in),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (res_out)
	);

	assign res.top_value    = res_out.top_value;
	assign res.stack_depth  = res_out.stack_depth;
	assign res.status       = res_out.status;
	assign res.program_done = res_out.program_done;

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_result_offered: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res.valid)
		else $error("accepted instruction left no result");

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cmd.action == ACT_FINISH) |=> (sp_q == '0))
		else $error("finish did not empty the stack");

	a_binop_pops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && sp_ge2 && (cmd.action == ACT_ADD || cmd.action == ACT_SUB ||
		cmd.action == ACT_MUL) |=> (sp_q == $past(sp_q) - SPW'(1)))
		else $error("arithmetic did not pop one entry");

endmodule

### sv/isc_stack_mem.sv
// Stack storage below the two cached top entries: one write port, one
// registered read port, with write-to-read forwarding. Depends on isc_pkg.
module isc_stack_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [isc_pkg::WORD_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [isc_pkg::WORD_W-1:0] rdata
);
	import isc_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_q;
	logic [WORD_W-1:0] wd_q;
	logic              fwd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
		wd_q <= wdata;
	end

	// A read of the entry being written in the same cycle must see the new word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= we && (waddr == raddr);
		end
	end

	assign rdata = fwd_q ? wd_q : rd_q;

endmodule

### sv/isc_out_buf.sv
// Two-entry result buffer between the execute logic and the result channel.
// Depends on isc_pkg for res_t.
module isc_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  isc_pkg::res_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output isc_pkg::res_t out_data
);
	import isc_pkg::*;

	res_t       head_q;
	res_t       tail_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			priority if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end else begin
				cnt_q <= cnt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (cnt_q == 2'd2) begin
			if (pop) begin
				head_q <= tail_q;
			end
		end else if (cnt_q == 2'd1) begin
			if (push && pop) begin
				head_q <= in_data;
			end else if (push) begin
				tail_q <= in_data;
			end
		end else begin
			if (push) begin
				head_q <= in_data;
			end
		end
	end

endmodule
